// ----- design/polyline_perimeter_macros.svh -----
// Assertion macros used by the checker file of the polyline length block.
`ifndef POLYLINE_PERIMETER_MACROS_SVH
`define POLYLINE_PERIMETER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLP_ASSERT_NOW(lbl, clk_sig, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLP_ASSERT_NEXT(lbl, clk_sig, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/plp_pkg.sv -----
`default_nettype none

package plp_pkg;

	// Default coordinate width and number of fraction bits of a length.
	localparam int DEF_COORD_BITS = 16;
	localparam int DEF_FRAC_BITS  = 8;

	// Width of the running sum and of the total on the result port.
	localparam int SUM_BITS = 35;

	// Largest value the sum can hold; a larger sum is clipped to this.
	localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

endpackage

`default_nettype wire

// ----- design/plp_seglen.sv -----
`default_nettype none

// Length of one segment: squares dx and dy with a bit-serial shift-add
// multiplier, then takes the square root one result bit per cycle.
module plp_seglen #(
	parameter int COORD_BITS = plp_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS  = plp_pkg::DEF_FRAC_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [COORD_BITS:0]             dx,
	input  wire logic [COORD_BITS:0]             dy,
	output logic                                 done,
	output logic [COORD_BITS+FRAC_BITS:0]        root
);

	localparam int D_W    = COORD_BITS + 1;
	localparam int RAD_W  = 2 * D_W;
	localparam int ROOT_W = COORD_BITS + FRAC_BITS + 1;
	localparam int REM_W  = ROOT_W + 2;
	localparam int CNT_W  = $clog2(ROOT_W);

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_SQ   = 3'b010,
		U_RT   = 3'b100
	} ust_t;

	ust_t              ust_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [D_W-1:0]    mx_q;
	logic [D_W-1:0]    my_q;
	logic [RAD_W-1:0]  ax_q;
	logic [RAD_W-1:0]  ay_q;
	logic [RAD_W-1:0]  acc_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [RAD_W-1:0]  pp_x;
	logic [RAD_W-1:0]  pp_y;
	logic [RAD_W-1:0]  acc_add;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	// One multiplier bit of each square per cycle.
	assign pp_x    = mx_q[0] ? ax_q : '0;
	assign pp_y    = my_q[0] ? ay_q : '0;
	assign acc_add = acc_q + pp_x + pp_y;

	// Restoring square root step: bring down the next radicand bit pair.
	assign rem_sh = {rem_q[REM_W-3:0], acc_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	// Sequencer: square phase, then root phase, then a done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ust_q  <= U_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (ust_q == U_RT) && (cnt_q == '0);
			case (ust_q)
				U_IDLE: begin
					if (start) begin
						ust_q <= U_SQ;
						cnt_q <= CNT_W'(D_W - 1);
					end
				end
				U_SQ: begin
					if (cnt_q == '0) begin
						ust_q <= U_RT;
						cnt_q <= CNT_W'(ROOT_W - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				U_RT: begin
					if (cnt_q == '0) begin
						ust_q <= U_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					ust_q <= U_IDLE;
				end
			endcase
		end
	end

	// Datapath shift registers; the accumulator becomes the radicand.
	always_ff @(posedge clk) begin
		if (ust_q == U_IDLE) begin
			if (start) begin
				mx_q   <= dx;
				my_q   <= dy;
				ax_q   <= RAD_W'(dx);
				ay_q   <= RAD_W'(dy);
				acc_q  <= '0;
				rem_q  <= '0;
				root_q <= '0;
			end
		end else if (ust_q == U_SQ) begin
			mx_q  <= mx_q >> 1;
			my_q  <= my_q >> 1;
			ax_q  <= ax_q << 1;
			ay_q  <= ay_q << 1;
			acc_q <= acc_add;
		end else if (ust_q == U_RT) begin
			acc_q  <= {acc_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ----- design/polyline_perimeter.sv -----
// A vertex after the first is stalled on while its segment runs through the serial squaring
// and the bit-serial square root; only then is the next vertex taken.
// A last vertex in closed mode runs a second segment before the emit state loads the result.
// A first vertex that is not last is taken without a segment. The result register lets the next
// chain start while a total still waits. Reset (arst_n low) clears the chain and the mode.
`default_nettype none

module polyline_perimeter #(
	parameter int COORD_BITS = plp_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS  = plp_pkg::DEF_FRAC_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          closed_chain,
	input  wire logic                          vertex_valid,
	output logic                               vertex_stall,
	input  wire logic signed [COORD_BITS-1:0]  x_coord,
	input  wire logic signed [COORD_BITS-1:0]  y_coord,
	input  wire logic                          last_point,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [plp_pkg::SUM_BITS-1:0]       total_length,
	output logic                               saturated
);

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int ROOT_W = COORD_BITS + FRAC_BITS + 1;
	localparam int SUM_W  = plp_pkg::SUM_BITS;
	localparam int EXT_W  = ((ROOT_W > SUM_W) ? ROOT_W : SUM_W) + 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SEG   = 4'b0010,
		ST_CLOSE = 4'b0100,
		ST_EMIT  = 4'b1000
	} st_t;

	st_t                    state_q;
	logic                   closed_q;
	logic                   have_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   clip_q;
	logic                   result_valid_q;
	logic                   last_q;
	logic [COORD_BITS-1:0]  first_x_q;
	logic [COORD_BITS-1:0]  first_y_q;
	logic [COORD_BITS-1:0]  prev_x_q;
	logic [COORD_BITS-1:0]  prev_y_q;
	logic [SUM_W-1:0]       total_q;
	logic                   sat_q;

	logic                   accept;
	logic                   load_result;
	logic [COORD_BITS-1:0]  a_x;
	logic [COORD_BITS-1:0]  a_y;
	logic [COORD_BITS-1:0]  b_x;
	logic [COORD_BITS-1:0]  b_y;
	logic [DIFF_W-1:0]      diff_x;
	logic [DIFF_W-1:0]      diff_y;
	logic [DIFF_W-1:0]      mag_x;
	logic [DIFF_W-1:0]      mag_y;
	logic                   seg_start;
	logic                   seg_done;
	logic [ROOT_W-1:0]      seg_root;
	logic [EXT_W-1:0]       sum_wide;
	logic                   over;
	logic [SUM_W-1:0]       sum_next;

	assign cfg_ready    = 1'b1;
	assign vertex_stall = (state_q != ST_IDLE);
	assign accept       = vertex_valid && !vertex_stall;
	assign load_result  = (state_q == ST_EMIT) && (!result_valid_q || !result_stall);

	// Segment end points: new vertex to previous one, or last vertex back to first.
	always_comb begin
		if (state_q == ST_IDLE) begin
			a_x = x_coord;
			a_y = y_coord;
			b_x = prev_x_q;
			b_y = prev_y_q;
		end else begin
			a_x = prev_x_q;
			a_y = prev_y_q;
			b_x = first_x_q;
			b_y = first_y_q;
		end
	end

	// Absolute coordinate differences, one bit wider than a coordinate.
	assign diff_x = {a_x[COORD_BITS-1], a_x} - {b_x[COORD_BITS-1], b_x};
	assign diff_y = {a_y[COORD_BITS-1], a_y} - {b_y[COORD_BITS-1], b_y};
	assign mag_x  = diff_x[DIFF_W-1] ? (~diff_x + DIFF_W'(1)) : diff_x;
	assign mag_y  = diff_y[DIFF_W-1] ? (~diff_y + DIFF_W'(1)) : diff_y;

	assign seg_start = (accept && have_q)
		|| ((state_q == ST_SEG) && seg_done && last_q && closed_q);

	plp_seglen #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_seglen (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seg_start),
		.dx     (mag_x),
		.dy     (mag_y),
		.done   (seg_done),
		.root   (seg_root)
	);

	// Saturating add of a finished segment to the running sum.
	assign sum_wide = EXT_W'(sum_q) + EXT_W'(seg_root);
	assign over     = (sum_wide > EXT_W'(plp_pkg::SUM_MAX));
	assign sum_next = over ? plp_pkg::SUM_MAX : sum_wide[SUM_W-1:0];

	// Chain control, running sum and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			closed_q       <= 1'b0;
			have_q         <= 1'b0;
			sum_q          <= '0;
			clip_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				closed_q <= closed_chain;
			end
			// The result valid rises when a total is loaded and falls when it is taken.
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!have_q) begin
							have_q  <= 1'b1;
							state_q <= last_point ? ST_EMIT : ST_IDLE;
						end else begin
							state_q <= ST_SEG;
						end
					end
				end
				ST_SEG: begin
					if (seg_done) begin
						sum_q  <= sum_next;
						clip_q <= clip_q | over;
						if (last_q) begin
							state_q <= closed_q ? ST_CLOSE : ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CLOSE: begin
					if (seg_done) begin
						sum_q   <= sum_next;
						clip_q  <= clip_q | over;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_result) begin
						have_q  <= 1'b0;
						sum_q   <= '0;
						clip_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Vertex and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q <= x_coord;
			prev_y_q <= y_coord;
			last_q   <= last_point;
			if (!have_q) begin
				first_x_q <= x_coord;
				first_y_q <= y_coord;
			end
		end
		if (load_result) begin
			total_q <= sum_q;
			sat_q   <= clip_q;
		end
	end

	assign result_valid = result_valid_q;
	assign total_length = total_q;
	assign saturated    = sat_q;

endmodule

`default_nettype wire

// ----- design/plp_port_checker.sv -----
`default_nettype none

`include "polyline_perimeter_macros.svh"

// Checks on the top level's ports over time.
module plp_port_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          vertex_valid,
	input wire logic                          vertex_stall,
	input wire logic                          last_point,
	input wire logic                          result_valid,
	input wire logic                          result_stall,
	input wire logic [plp_pkg::SUM_BITS-1:0]  total_length,
	input wire logic                          saturated
);

	// A stalled result item stays put.
	`PLP_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(total_length) && $stable(saturated), "stalled result item changed")

	// A clipped total reads as the largest sum.
	`PLP_ASSERT_NOW(a_sat_max, clk, arst_n, result_valid && saturated, &total_length, "saturated total is not the maximum")

	// The last vertex of a chain keeps the input stalled while the total is formed.
	`PLP_ASSERT_NEXT(a_last_busy, clk, arst_n, vertex_valid && !vertex_stall && last_point, vertex_stall, "input not stalled after last vertex")

	// A new result item is only loaded while the input is stalled.
	`PLP_ASSERT_NOW(a_result_src, clk, arst_n, $rose(result_valid), $past(vertex_stall), "result item appeared without a busy cycle")

endmodule

bind polyline_perimeter plp_port_checker u_plp_port_checker (.*);

`default_nettype wire

// ----- tb/tb_polyline_perimeter.sv -----
`timescale 1ns / 100ps

module tb_polyline_perimeter;

	localparam int CW            = plp_pkg::DEF_COORD_BITS;
	localparam int FB            = plp_pkg::DEF_FRAC_BITS;
	localparam int LIMIT_CYCLES  = 2_000_000;
	// A closed last vertex runs two segments and then loads the result.
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 600;
	localparam int RANDOM_PHASE  = 295;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [plp_pkg::SUM_BITS-1:0] total;
		logic                         sat;
	} chain_total_t;

	// One row of the directed part; the typed total applies only where typed is set.
	typedef struct packed {
		logic                         set_mode;
		logic                         mode;
		logic signed [CW-1:0]         x;
		logic signed [CW-1:0]         y;
		logic                         is_last;
		logic                         typed;
		logic [plp_pkg::SUM_BITS-1:0] total;
		logic                         sat;
	} vertex_row_t;

	localparam int DIRECTED_ROWS = 21;

	vertex_row_t directed_rows [DIRECTED_ROWS] = '{
		'{1, 0,      0,      0, 1, 1,        0, 0},
		'{0, 0,      0,      0, 0, 0,        0, 0},
		'{0, 0,      3,      4, 1, 1,     1280, 0},
		'{0, 0, -32768,      0, 0, 0,        0, 0},
		'{0, 0,  32767,      0, 1, 1, 16776960, 0},
		'{0, 0,      0,  32767, 0, 0,        0, 0},
		'{0, 0,      0, -32768, 1, 1, 16776960, 0},
		'{0, 0, -32768, -32768, 0, 0,        0, 0},
		'{0, 0,  32767,  32767, 0, 0,        0, 0},
		'{0, 0, -32768,  32767, 1, 0,        0, 0},
		'{0, 0,      5,      5, 0, 0,        0, 0},
		'{0, 0,      5,      5, 1, 1,        0, 0},
		'{1, 1,     -1,     -1, 1, 1,        0, 0},
		'{0, 0,      0,      0, 0, 0,        0, 0},
		'{0, 0,      1,      0, 0, 0,        0, 0},
		'{0, 0,      1,      1, 0, 0,        0, 0},
		'{0, 0,      0,      1, 1, 1,     1024, 0},
		'{0, 0,  32767, -32768, 0, 0,        0, 0},
		'{0, 0, -32768,  32767, 1, 0,        0, 0},
		'{0, 0,      7,    -24, 0, 0,        0, 0},
		'{0, 0,      0,      0, 1, 1,    12800, 0}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic                          closed_chain;
	logic                          vertex_valid;
	logic                          vertex_stall;
	logic signed [CW-1:0]          x_coord;
	logic signed [CW-1:0]          y_coord;
	logic                          last_point;
	logic                          result_valid;
	logic                          result_stall;
	logic [plp_pkg::SUM_BITS-1:0]  total_length;
	logic                          saturated;

	// Predictor state: the open chain and the mode the block should hold.
	logic signed [CW-1:0]          first_x, first_y, prev_x, prev_y;
	bit                            chain_open;
	logic [plp_pkg::SUM_BITS-1:0]  run_sum;
	bit                            run_clipped;
	bit                            closed_mode;

	chain_total_t          pending_totals [$];
	int unsigned           vertices_sent;
	int unsigned           totals_seen;
	int unsigned           failures;
	int unsigned           cycle_count;
	bit                    sender_quiet;

	polyline_perimeter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.closed_chain (closed_chain),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.last_point   (last_point),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.total_length (total_length),
		.saturated    (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Segment length as floor(sqrt(dx*dx + dy*dy) * 2^FB), found by trial squaring.
	function automatic logic [plp_pkg::SUM_BITS-1:0] scaled_hypot(
			input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
			input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by);
		longint          dx, dy;
		longint unsigned radicand, root, trial;
		int              b;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		radicand = longint'(dx * dx + dy * dy) << (2 * FB);
		root = 0;
		for (b = CW + FB; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= radicand)
				root = trial;
		end
		return root[plp_pkg::SUM_BITS-1:0];
	endfunction

	// Adds one segment to the running sum, clipping at the largest value.
	function automatic void add_length(input logic [plp_pkg::SUM_BITS-1:0] seg);
		if (seg > plp_pkg::SUM_MAX - run_sum) begin
			run_sum     = plp_pkg::SUM_MAX;
			run_clipped = 1'b1;
		end else begin
			run_sum = run_sum + seg;
		end
	endfunction

	// Advances the predicted chain by one vertex; returns 1 when a total is due.
	function automatic bit chain_step(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y, input logic is_last, output chain_total_t r);
		r = '0;
		if (!chain_open) begin
			first_x    = x;
			first_y    = y;
			chain_open = 1'b1;
		end else begin
			add_length(scaled_hypot(prev_x, prev_y, x, y));
		end
		prev_x = x;
		prev_y = y;
		if (!is_last)
			return 1'b0;
		if (closed_mode)
			add_length(scaled_hypot(x, y, first_x, first_y));
		r.total     = run_sum;
		r.sat       = run_clipped;
		first_x     = '0;
		first_y     = '0;
		prev_x      = '0;
		prev_y      = '0;
		chain_open  = 1'b0;
		run_sum     = '0;
		run_clipped = 1'b0;
		return 1'b1;
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Coordinates: full range, tiny, extremes, or moderate.
	function automatic logic signed [CW-1:0] rand_coord();
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = int'($urandom_range(0, 32)) - 16;
			2: begin
				case ($urandom_range(0, 3))
					0: v = -32768;
					1: v = 32767;
					2: v = -1;
					default: v = 0;
				endcase
			end
			default: v = int'($urandom_range(0, 2047)) - 1024;
		endcase
		return v[CW-1:0];
	endfunction

	// Offers one vertex until it is taken, then books the total it should yield.
	task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
			input logic is_last, input bit typed,
			input logic [plp_pkg::SUM_BITS-1:0] t_total, input logic t_sat);
		chain_total_t r;
		bit           accepted;
		vertex_valid <= 1'b1;
		x_coord      <= x;
		y_coord      <= y;
		last_point   <= is_last;
		do begin
			@(negedge clk);
			accepted = !vertex_stall;
			@(posedge clk);
		end while (!accepted);
		if (chain_step(x, y, is_last, r)) begin
			if (typed) begin
				r.total = t_total;
				r.sat   = t_sat;
			end
			pending_totals.push_back(r);
		end
		vertices_sent++;
	endtask

	// Drops valid for a random gap after an item, except in quiet stretches.
	task automatic idle_after_vertex();
		int unsigned gap;
		if ($urandom_range(0, 49) == 0)
			sender_quiet = !sender_quiet;
		gap = sender_quiet ? 0 : pick_gap();
		if (gap != 0) begin
			vertex_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Changes the chain mode once every booked total is back and the block has settled.
	task automatic write_mode(input logic m);
		bit accepted;
		vertex_valid <= 1'b0;
		while (pending_totals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid    <= 1'b1;
		closed_chain <= m;
		do begin
			@(negedge clk);
			accepted = cfg_ready;
			@(posedge clk);
		end while (!accepted);
		cfg_valid   <= 1'b0;
		closed_mode  = m;
	endtask

	// One chain of random length and content; long chains are rare.
	task automatic random_chain();
		int unsigned kind, n, i;
		kind = $urandom_range(0, 99);
		if (kind < 70)
			n = $urandom_range(1, 5);
		else if (kind < 95)
			n = $urandom_range(6, 16);
		else
			n = $urandom_range(17, 40);
		for (i = 0; i < n; i++) begin
			send_vertex(rand_coord(), rand_coord(), i == n - 1, 1'b0, '0, 1'b0);
			idle_after_vertex();
		end
	endtask

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: random stalls, quiet stretches, and one long hold-off.
	initial begin
		int unsigned n;
		bit          held, quiet, s;
		result_stall <= 1'b0;
		held  = 1'b0;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && totals_seen >= 40) begin
				held = 1'b1;
				s    = 1'b1;
				n    = HOLD_CYCLES;
			end else begin
				if ($urandom_range(0, 29) == 0)
					quiet = !quiet;
				s = quiet ? 1'b0 : ($urandom_range(0, 99) < 35);
				n = quiet ? 20 : pick_gap() + 1;
			end
			result_stall <= s;
			repeat (n) @(posedge clk);
		end
	end

	// Compares each accepted total with the oldest one booked.
	always @(negedge clk) begin
		chain_total_t want;
		if (arst_n && result_valid && !result_stall) begin
			totals_seen++;
			if (pending_totals.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("unexpected total: total=%0d sat=%0b", total_length, saturated);
			end else begin
				want = pending_totals.pop_front();
				if (total_length !== want.total || saturated !== want.sat) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("total mismatch: expected total=%0d sat=%0b, got total=%0d sat=%0b",
							want.total, want.sat, total_length, saturated);
				end
			end
		end
	end

	// Stimulus: directed rows, then random phases in both modes.
	initial begin
		int          i;
		int unsigned target;
		logic        phase_modes [4];
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		closed_chain <= 1'b0;
		vertex_valid <= 1'b0;
		x_coord      <= '0;
		y_coord      <= '0;
		last_point   <= 1'b0;
		phase_modes   = '{1'b0, 1'b1, 1'b0, 1'b1};
		first_x       = '0;
		first_y       = '0;
		prev_x        = '0;
		prev_y        = '0;
		chain_open    = 1'b0;
		run_sum       = '0;
		run_clipped   = 1'b0;
		closed_mode   = 1'b0;
		sender_quiet  = 1'b0;
		vertices_sent = 0;
		totals_seen   = 0;
		failures      = 0;
		cycle_count   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_rows[i].set_mode)
				write_mode(directed_rows[i].mode);
			send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].is_last,
				directed_rows[i].typed, directed_rows[i].total, directed_rows[i].sat);
			idle_after_vertex();
		end

		foreach (phase_modes[p]) begin
			write_mode(phase_modes[p]);
			target = vertices_sent + RANDOM_PHASE;
			while (vertices_sent < target)
				random_chain();
		end

		vertex_valid <= 1'b0;
		while (pending_totals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		failures += pending_totals.size();
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
